// ----- hdl/thc_pkg.sv -----
// shared constants, types and codes for the two-level cache hierarchy
`timescale 1ns / 1ps
package thc_pkg;

    localparam int FIRST_SETS        = 64;
    localparam int FIRST_WAYS        = 4;
    localparam int SECOND_SETS       = 512;
    localparam int SECOND_WAYS       = 8;
    localparam int FIRST_LINE_BYTES  = 64;
    localparam int SECOND_LINE_BYTES = 64;

    localparam int ADDR_W = 32;

    localparam int F_OFF_W = $clog2(FIRST_LINE_BYTES);
    localparam int F_SET_W = $clog2(FIRST_SETS);
    localparam int F_TAG_W = ADDR_W - F_OFF_W - F_SET_W;
    localparam int S_OFF_W = $clog2(SECOND_LINE_BYTES);
    localparam int S_SET_W = $clog2(SECOND_SETS);
    localparam int S_TAG_W = ADDR_W - S_OFF_W - S_SET_W;

    // first level rows: instruction sets then data sets
    localparam int F_ROWS  = 2 * FIRST_SETS;
    localparam int S_ROWS  = SECOND_SETS;
    localparam int F_IDX_W = $clog2(F_ROWS);
    localparam int S_IDX_W = (S_ROWS > 1) ? $clog2(S_ROWS) : 1;

    localparam int MAX_WAYS  = (FIRST_WAYS > SECOND_WAYS) ? FIRST_WAYS : SECOND_WAYS;
    localparam int MAX_TAG_W = (F_TAG_W > S_TAG_W) ? F_TAG_W : S_TAG_W;
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int F_RANK_W  = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
    localparam int S_RANK_W  = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;

    localparam int CLR_ROWS = (F_ROWS > S_ROWS) ? F_ROWS : S_ROWS;
    localparam int CLR_W    = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

    localparam int LAT_W      = 8;
    localparam int MEM_LAT_W  = 10;
    localparam int TOTAL_W    = 11;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam logic [MEM_LAT_W-1:0] MEM_LAT_RESET = MEM_LAT_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INST_L1_LAT = 3'd0,
        CFG_DATA_L1_LAT = 3'd1,
        CFG_L2_LAT      = 3'd2,
        CFG_MEM_LAT     = 3'd3,
        CFG_L1_POLICY   = 3'd4,
        CFG_L2_POLICY   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } state_t;

    // common way view used by the shared lookup unit
    typedef struct packed {
        logic                 valid;
        logic [MAX_TAG_W-1:0] tag;
        logic [RANK_W-1:0]    rec;
        logic [RANK_W-1:0]    ins;
    } way_t;
    typedef way_t [MAX_WAYS-1:0] set_t;

    typedef struct packed {
        logic               valid;
        logic [F_TAG_W-1:0] tag;
        logic [F_RANK_W-1:0] rec;
        logic [F_RANK_W-1:0] ins;
    } f_way_t;
    typedef f_way_t [FIRST_WAYS-1:0] f_row_t;

    typedef struct packed {
        logic               valid;
        logic [S_TAG_W-1:0] tag;
        logic [S_RANK_W-1:0] rec;
        logic [S_RANK_W-1:0] ins;
    } s_way_t;
    typedef s_way_t [SECOND_WAYS-1:0] s_row_t;

endpackage

// ----- hdl/thc_req_if.sv -----
// request channel interface
`timescale 1ns / 1ps
interface thc_req_if import thc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] byte_addr;

    modport source (output valid, req_type, byte_addr, input ready);
    modport sink (input valid, req_type, byte_addr, output ready);
endinterface

// ----- hdl/thc_rsp_if.sv -----
// result channel interface
`timescale 1ns / 1ps
interface thc_rsp_if import thc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_latency;
    logic               first_hit;
    logic               second_hit;
    logic [COUNT_W-1:0] first_access_count;
    logic [COUNT_W-1:0] first_miss_count;

    modport source (output valid, total_latency, first_hit, second_hit,
                    first_access_count, first_miss_count, input ready);
    modport sink (input valid, total_latency, first_hit, second_hit,
                  first_access_count, first_miss_count, output ready);
endinterface

// ----- hdl/thc_ram.sv -----
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps
module thc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hdl/thc_lookup.sv -----
// set lookup, hit promotion and victim allocation for one set
`timescale 1ns / 1ps
module thc_lookup import thc_pkg::*; (
    input  set_t                 row_in,
    input  logic [MAX_TAG_W-1:0] tag,
    input  logic                 second,
    input  logic                 fifo,
    output logic                 hit,
    output set_t                 row_out
);
    always_comb
    begin
        int nways;
        int hw;
        int fw;
        int vw;
        logic found;
        logic free;
        logic [RANK_W:0] nv;
        logic [RANK_W-1:0] old_rec;
        logic [RANK_W-1:0] old_ins;
        logic [RANK_W-1:0] kmin;
        logic [RANK_W-1:0] k;

        nways = second ? SECOND_WAYS : FIRST_WAYS;
        nv = '0;
        hw = 0;
        fw = 0;
        vw = 0;
        found = 1'b0;
        free = 1'b0;
        row_out = row_in;

        // count valid ways, first matching tag
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < nways && row_in[i].valid)
            begin
                nv = nv + 1'b1;
                if (!found && row_in[i].tag == tag)
                begin
                    found = 1'b1;
                    hw = i;
                end
            end
        end
        hit = found;

        // lowest invalid way
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < nways && !row_in[i].valid && !free)
            begin
                free = 1'b1;
                fw = i;
            end
        end

        // oldest way under the chosen policy
        kmin = fifo ? row_in[0].ins : row_in[0].rec;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            k = fifo ? row_in[i].ins : row_in[i].rec;
            if (i < nways && k < kmin)
            begin
                kmin = k;
                vw = i;
            end
        end

        old_rec = found ? row_in[hw].rec : row_in[vw].rec;
        old_ins = row_in[vw].ins;

        if (found)
        begin
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (i < nways && i != hw && row_in[i].valid && row_in[i].rec > old_rec)
                begin
                    row_out[i].rec = row_in[i].rec - 1'b1;
                end
            end
            row_out[hw].rec = RANK_W'(nv - 1'b1);
        end
        else if (free)
        begin
            row_out[fw].valid = 1'b1;
            row_out[fw].tag = tag;
            row_out[fw].rec = RANK_W'(nv);
            row_out[fw].ins = RANK_W'(nv);
        end
        else
        begin
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (i < nways && i != vw)
                begin
                    if (row_in[i].rec > old_rec)
                    begin
                        row_out[i].rec = row_in[i].rec - 1'b1;
                    end
                    if (row_in[i].ins > old_ins)
                    begin
                        row_out[i].ins = row_in[i].ins - 1'b1;
                    end
                end
            end
            row_out[vw].rec = RANK_W'(nways - 1);
            row_out[vw].ins = RANK_W'(nways - 1);
            row_out[vw].tag = tag;
        end
    end
endmodule

// ----- hdl/two_level_cache_hierarchy_top.sv -----
// top level of the two-level cache hierarchy timing block
`timescale 1ns / 1ps
// requests come in on req (req_type, byte_addr) under valid/ready; each
// accepted word gives exactly one result word on rsp: summed latency, hit
// flags for both levels and the saturating first-level access/miss counts
// configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user does so only while the block is idle, unenforced; unknown indexes ignored
// the first level (instruction and data sets in one memory) and the shared
// second level each keep one whole set per memory row, read through a
// registered port, then updated and written back by the shared lookup unit
// a first-level hit loads the result register from ST_FIRST once the output
// slot is free; a first-level miss adds a second-level row read and loads it
// from ST_SECOND; new requests are taken only in ST_IDLE, so with the
// read-modify-write of the set rows one request is worked at a time
// after reset a clearing pass over 512 rows (the second-level row count)
// zeroes every row; req.ready stays low during it, configuration is taken
// a result waits in the output register while rsp.ready is low; the block
// finishes the next request up to the point of writing its result, then holds
module two_level_cache_hierarchy_top import thc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    thc_req_if.sink               req,
    thc_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    // configuration registers
    logic [LAT_W-1:0]     inst_lat_reg;
    logic [LAT_W-1:0]     data_lat_reg;
    logic [LAT_W-1:0]     l2_lat_reg;
    logic [MEM_LAT_W-1:0] mem_lat_reg;
    logic                 l1_pol_reg;
    logic                 l2_pol_reg;

    // control state
    state_t               state_reg, state_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic [COUNT_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]   miss_reg, miss_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // request held while it is worked on
    logic                 type_reg, type_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [F_IDX_W-1:0]   fidx_reg, fidx_next;
    logic [TOTAL_W-1:0]   lat_reg, lat_next;

    // result payload
    logic [TOTAL_W-1:0]   out_lat_reg, out_lat_next;
    logic                 out_h1_reg, out_h1_next;
    logic                 out_h2_reg, out_h2_next;
    logic [COUNT_W-1:0]   out_acc_reg, out_acc_next;
    logic [COUNT_W-1:0]   out_miss_reg, out_miss_next;

    // memory ports
    logic                 f_we, f_re, s_we, s_re;
    logic [F_IDX_W-1:0]   f_waddr, f_raddr;
    logic [S_IDX_W-1:0]   s_idx, s_waddr;
    f_row_t               f_wdata, f_rdata, f_new;
    s_row_t               s_wdata, s_rdata, s_new;

    // lookup unit
    set_t                 f_gen, s_gen, lk_in, lk_out;
    logic [MAX_TAG_W-1:0] lk_tag, f_tag, s_tag;
    logic                 lk_second, lk_fifo, lk_hit;

    logic                 slot_free;
    logic [TOTAL_W-1:0]   lat1;
    logic [COUNT_W-1:0]   acc_inc, miss_inc;

    function automatic logic [MEM_LAT_W-1:0] at_least_one(input logic [MEM_LAT_W-1:0] v);
        return (v == '0) ? MEM_LAT_W'(1) : v;
    endfunction

    thc_ram #(.DEPTH(F_ROWS), .WIDTH($bits(f_row_t))) u_first_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    thc_ram #(.DEPTH(S_ROWS), .WIDTH($bits(s_row_t))) u_second_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_idx),
        .rdata (s_rdata)
    );

    thc_lookup u_lookup (
        .row_in  (lk_in),
        .tag     (lk_tag),
        .second  (lk_second),
        .fifo    (lk_fifo),
        .hit     (lk_hit),
        .row_out (lk_out)
    );

    // address split
    assign f_raddr = F_IDX_W'(32'(req.req_type) * FIRST_SETS
                              + ((req.byte_addr >> F_OFF_W) % FIRST_SETS));
    assign f_tag   = MAX_TAG_W'(F_TAG_W'((addr_reg >> F_OFF_W) / FIRST_SETS));
    assign s_idx   = S_IDX_W'((addr_reg >> S_OFF_W) % SECOND_SETS);
    assign s_tag   = MAX_TAG_W'(S_TAG_W'((addr_reg >> S_OFF_W) / SECOND_SETS));

    // widen stored rows to the lookup view and narrow them back
    always_comb
    begin
        f_gen = '0;
        s_gen = '0;
        for (int i = 0; i < FIRST_WAYS; i++)
        begin
            f_gen[i].valid = f_rdata[i].valid;
            f_gen[i].tag   = MAX_TAG_W'(f_rdata[i].tag);
            f_gen[i].rec   = RANK_W'(f_rdata[i].rec);
            f_gen[i].ins   = RANK_W'(f_rdata[i].ins);
        end
        for (int i = 0; i < SECOND_WAYS; i++)
        begin
            s_gen[i].valid = s_rdata[i].valid;
            s_gen[i].tag   = MAX_TAG_W'(s_rdata[i].tag);
            s_gen[i].rec   = RANK_W'(s_rdata[i].rec);
            s_gen[i].ins   = RANK_W'(s_rdata[i].ins);
        end
    end

    always_comb
    begin
        for (int i = 0; i < FIRST_WAYS; i++)
        begin
            f_new[i].valid = lk_out[i].valid;
            f_new[i].tag   = F_TAG_W'(lk_out[i].tag);
            f_new[i].rec   = F_RANK_W'(lk_out[i].rec);
            f_new[i].ins   = F_RANK_W'(lk_out[i].ins);
        end
        for (int i = 0; i < SECOND_WAYS; i++)
        begin
            s_new[i].valid = lk_out[i].valid;
            s_new[i].tag   = S_TAG_W'(lk_out[i].tag);
            s_new[i].rec   = S_RANK_W'(lk_out[i].rec);
            s_new[i].ins   = S_RANK_W'(lk_out[i].ins);
        end
    end

    assign lk_second = (state_reg == ST_SECOND);
    assign lk_in     = lk_second ? s_gen : f_gen;
    assign lk_tag    = lk_second ? s_tag : f_tag;
    assign lk_fifo   = lk_second ? l2_pol_reg : l1_pol_reg;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign lat1      = TOTAL_W'(at_least_one(MEM_LAT_W'(type_reg ? data_lat_reg
                                                                : inst_lat_reg)));
    assign acc_inc   = (acc_reg == '1) ? acc_reg : acc_reg + 1'b1;
    assign miss_inc  = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        acc_next       = acc_reg;
        miss_next      = miss_reg;
        type_next      = type_reg;
        addr_next      = addr_reg;
        fidx_next      = fidx_reg;
        lat_next       = lat_reg;
        out_lat_next   = out_lat_reg;
        out_h1_next    = out_h1_reg;
        out_h2_next    = out_h2_reg;
        out_acc_next   = out_acc_reg;
        out_miss_next  = out_miss_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        req.ready      = 1'b0;
        f_we           = 1'b0;
        f_re           = 1'b0;
        s_we           = 1'b0;
        s_re           = 1'b0;
        f_waddr        = fidx_reg;
        s_waddr        = s_idx;
        f_wdata        = f_new;
        s_wdata        = s_new;

        case (state_reg)
            ST_CLEAR:
            begin
                // zero every row: no valid ways, ranks zero
                f_we    = 1'b1;
                s_we    = 1'b1;
                f_waddr = F_IDX_W'(clr_reg);
                s_waddr = S_IDX_W'(clr_reg);
                f_wdata = '0;
                s_wdata = '0;
                if (clr_reg == CLR_W'(CLR_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                f_re      = req.valid;
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    addr_next  = req.byte_addr;
                    fidx_next  = f_raddr;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (lk_hit)
                begin
                    if (slot_free)
                    begin
                        f_we           = 1'b1;
                        acc_next       = acc_inc;
                        out_lat_next   = lat1;
                        out_h1_next    = 1'b1;
                        out_h2_next    = 1'b0;
                        out_acc_next   = acc_inc;
                        out_miss_next  = miss_reg;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // refill first level now, second level row read follows
                    f_we       = 1'b1;
                    s_re       = 1'b1;
                    acc_next   = acc_inc;
                    miss_next  = miss_inc;
                    lat_next   = lat1 + TOTAL_W'(at_least_one(MEM_LAT_W'(l2_lat_reg)));
                    state_next = ST_SECOND;
                end
            end
            ST_SECOND:
            begin
                if (slot_free)
                begin
                    s_we           = 1'b1;
                    out_lat_next   = lk_hit ? lat_reg
                                            : lat_reg + TOTAL_W'(at_least_one(mem_lat_reg));
                    out_h1_next    = 1'b0;
                    out_h2_next    = lk_hit;
                    out_acc_next   = acc_reg;
                    out_miss_next  = miss_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            acc_reg       <= acc_next;
            miss_reg      <= miss_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        addr_reg     <= addr_next;
        fidx_reg     <= fidx_next;
        lat_reg      <= lat_next;
        out_lat_reg  <= out_lat_next;
        out_h1_reg   <= out_h1_next;
        out_h2_reg   <= out_h2_next;
        out_acc_reg  <= out_acc_next;
        out_miss_reg <= out_miss_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inst_lat_reg <= LAT_W'(1);
            data_lat_reg <= LAT_W'(1);
            l2_lat_reg   <= LAT_W'(1);
            mem_lat_reg  <= MEM_LAT_RESET;
            l1_pol_reg   <= 1'b0;
            l2_pol_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INST_L1_LAT: inst_lat_reg <= cfg_wdata[LAT_W-1:0];
                CFG_DATA_L1_LAT: data_lat_reg <= cfg_wdata[LAT_W-1:0];
                CFG_L2_LAT:      l2_lat_reg   <= cfg_wdata[LAT_W-1:0];
                CFG_MEM_LAT:     mem_lat_reg  <= cfg_wdata[MEM_LAT_W-1:0];
                CFG_L1_POLICY:   l1_pol_reg   <= cfg_wdata[0];
                CFG_L2_POLICY:   l2_pol_reg   <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.total_latency      = out_lat_reg;
    assign rsp.first_hit          = out_h1_reg;
    assign rsp.second_hit         = out_h2_reg;
    assign rsp.first_access_count = out_acc_reg;
    assign rsp.first_miss_count   = out_miss_reg;
endmodule
